>>> design/bpss_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpss_pkg
// Shared constants for the specular shading pipeline.
// ----------------------------------------------------------------------------
package bpss_pkg;

  localparam int ROUGH_W   = 16;   // roughness code, Q0.16
  localparam int WEIGHT_W  = 16;   // specular weight, Q1.15
  localparam int LG_FRAC   = 16;   // fraction bits of the log2 values
  localparam int DIV_STEPS = 21;   // quotient bits kept by the divider
  localparam int Q_LIMIT   = 17;   // integer part at which intensity is zero
  localparam int INT_W     = 17;   // intensity width, Q0.16 up to 1.0
  localparam int PRE_STAGES  = 7;
  localparam int POST_STAGES = 4;
  localparam int LATENCY   = PRE_STAGES + DIV_STEPS + POST_STAGES;

endpackage

>>> design/blinn_phong_specular_shade.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blinn_phong_specular_shade
// Blinn-Phong specular highlight added to a running color, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   A word is taken at each rising edge where start is high and busy is low.
//   busy is always low: the pipeline takes one word every cycle.
//   Each word gives eye, light and normal vectors, the running color, the
//   light and surface colors, roughness, specular weight and metallic flag.
//   The result shows on out_color_out for one cycle with out_valid high,
//   in input order. The stages are: 7 for the dot products, log2 terms
//   and divider setup, 21 stages of a restoring divider (one quotient bit
//   per stage) for the exponent, and 4 stages for exp2, weighting, tinting
//   and the saturating add. Throughput is one word per cycle.
//   The receiver cannot stall; results are presented once and move on.
//   Reset (rst_n low, synchronous) clears all valid bits; words in flight
//   are dropped and no strobe appears until new words arrive.
// ----------------------------------------------------------------------------
module blinn_phong_specular_shade #(
  parameter int COMPONENT_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [3*COMPONENT_BITS-1:0] in_eye_dir,
  input  logic [3*COMPONENT_BITS-1:0] in_light_dir,
  input  logic [3*COMPONENT_BITS-1:0] in_normal_vec,
  input  logic [3*COMPONENT_BITS-1:0] in_color_in,
  input  logic [3*COMPONENT_BITS-1:0] in_light_color,
  input  logic [3*COMPONENT_BITS-1:0] in_surface_color,
  input  logic [bpss_pkg::ROUGH_W-1:0]  in_roughness,
  input  logic [bpss_pkg::WEIGHT_W-1:0] in_specular_weight,
  input  logic                        in_metallic,
  output logic                        out_valid,
  output logic [3*COMPONENT_BITS-1:0] out_color_out
);
  import bpss_pkg::*;

  localparam int CW  = COMPONENT_BITS;
  localparam int VW  = 3 * CW;
  localparam int HW  = CW + 1;          // h component
  localparam int XW  = 2 * CW + 2;      // log2 operand width
  localparam int DW  = 2 * CW + 3;      // signed dot product
  localparam int PSW = $clog2(XW);
  localparam int LGW = PSW + LG_FRAC;
  localparam int SW  = INT_W + WEIGHT_W; // s, Q2.31
  localparam int TW  = CW + 2;          // term width

  assign busy = 1'b0;

  function automatic logic [PSW-1:0] lead_one(input logic [XW-1:0] x);
    logic [PSW-1:0] p;
    p = '0;
    for (int i = 0; i < XW; i++) begin
      if (x[i]) p = PSW'(i);
    end
    return p;
  endfunction

  function automatic logic [LG_FRAC-1:0] lg_frac(input logic [XW-1:0] x,
                                                 input logic [PSW-1:0] p);
    logic [XW+LG_FRAC-1:0] sh;
    sh = {x, {LG_FRAC{1'b0}}} >> p;
    return sh[LG_FRAC-1:0];
  endfunction

  logic in_acc;
  assign in_acc = start & ~busy;

  // ---------------- stage 1: halfway vector, tint select ----------------
  logic              v1_r;
  logic signed [HW-1:0] h1_r [3];
  logic signed [CW-1:0] n1_r [3];
  logic [VW-1:0]     col1_r, tint1_r;
  logic [WEIGHT_W-1:0] w1_r;
  logic [ROUGH_W-1:0]  r1_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      h1_r[i] <= HW'($signed(in_eye_dir[i*CW +: CW])) +
                 HW'($signed(in_light_dir[i*CW +: CW]));
      n1_r[i] <= $signed(in_normal_vec[i*CW +: CW]);
    end
    col1_r  <= in_color_in;
    tint1_r <= in_metallic ? in_surface_color : in_light_color;
    w1_r    <= in_specular_weight;
    r1_r    <= (in_roughness == '0) ? ROUGH_W'(1) : in_roughness;
  end

  // ---------------- stage 2: products ----------------
  logic              v2_r;
  logic signed [2*CW:0]   phn2_r [3];
  logic signed [2*CW+1:0] phh2_r [3];
  logic signed [2*CW-1:0] pnn2_r [3];
  logic [VW-1:0]     col2_r, tint2_r;
  logic [WEIGHT_W-1:0] w2_r;
  logic [ROUGH_W-1:0]  r2_r;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      phn2_r[i] <= (2*CW+1)'(h1_r[i]) * (2*CW+1)'(n1_r[i]);
      phh2_r[i] <= (2*CW+2)'(h1_r[i]) * (2*CW+2)'(h1_r[i]);
      pnn2_r[i] <= (2*CW)'(n1_r[i]) * (2*CW)'(n1_r[i]);
    end
    col2_r <= col1_r; tint2_r <= tint1_r; w2_r <= w1_r; r2_r <= r1_r;
  end

  // ---------------- stage 3: sums, zero test ----------------
  logic              v3_r, z3_r;
  logic [XW-1:0]     hh3_r, nn3_r, d3_r;
  logic [VW-1:0]     col3_r, tint3_r;
  logic [WEIGHT_W-1:0] w3_r;
  logic [ROUGH_W-1:0]  r3_r;
  logic signed [DW-1:0] d_nxt;
  logic [XW-1:0]     hh_nxt, nn_nxt;

  always_comb begin
    d_nxt  = DW'(phn2_r[0]) + DW'(phn2_r[1]) + DW'(phn2_r[2]);
    hh_nxt = XW'($unsigned(phh2_r[0])) + XW'($unsigned(phh2_r[1])) +
             XW'($unsigned(phh2_r[2]));
    nn_nxt = XW'($unsigned(pnn2_r[0])) + XW'($unsigned(pnn2_r[1])) +
             XW'($unsigned(pnn2_r[2]));
  end

  always_ff @(posedge clk) begin
    hh3_r <= hh_nxt;
    nn3_r <= nn_nxt;
    d3_r  <= d_nxt[XW-1:0];
    z3_r  <= (hh_nxt == '0) || (nn_nxt == '0) || (d_nxt <= 0);
    col3_r <= col2_r; tint3_r <= tint2_r; w3_r <= w2_r; r3_r <= r2_r;
  end

  // ---------------- stage 4: leading-one positions ----------------
  logic              v4_r, z4_r;
  logic [XW-1:0]     hh4_r, nn4_r, d4_r;
  logic [PSW-1:0]    phh4_r, pnn4_r, pd4_r;
  logic [VW-1:0]     col4_r, tint4_r;
  logic [WEIGHT_W-1:0] w4_r;
  logic [ROUGH_W-1:0]  r4_r;

  always_ff @(posedge clk) begin
    phh4_r <= lead_one(hh3_r);
    pnn4_r <= lead_one(nn3_r);
    pd4_r  <= lead_one(d3_r);
    hh4_r <= hh3_r; nn4_r <= nn3_r; d4_r <= d3_r; z4_r <= z3_r;
    col4_r <= col3_r; tint4_r <= tint3_r; w4_r <= w3_r; r4_r <= r3_r;
  end

  // ---------------- stage 5: Mitchell log2 ----------------
  logic              v5_r, z5_r;
  logic [LGW-1:0]    lhh5_r, lnn5_r, ld5_r;
  logic [VW-1:0]     col5_r, tint5_r;
  logic [WEIGHT_W-1:0] w5_r;
  logic [ROUGH_W-1:0]  r5_r;

  always_ff @(posedge clk) begin
    lhh5_r <= {phh4_r, lg_frac(hh4_r, phh4_r)};
    lnn5_r <= {pnn4_r, lg_frac(nn4_r, pnn4_r)};
    ld5_r  <= {pd4_r,  lg_frac(d4_r,  pd4_r)};
    z5_r <= z4_r;
    col5_r <= col4_r; tint5_r <= tint4_r; w5_r <= w4_r; r5_r <= r4_r;
  end

  // ---------------- stage 6: -log2(cos) ----------------
  logic              v6_r, z6_r;
  logic [LGW-1:0]    m6_r;
  logic [VW-1:0]     col6_r, tint6_r;
  logic [WEIGHT_W-1:0] w6_r;
  logic [ROUGH_W-1:0]  r6_r;
  logic [LGW:0]      num_c, den_c, dif_c;

  always_comb begin
    num_c = (LGW+1)'(lhh5_r) + (LGW+1)'(lnn5_r);
    den_c = {ld5_r, 1'b0};
    dif_c = num_c - den_c;
  end

  always_ff @(posedge clk) begin
    m6_r <= (num_c > den_c) ? dif_c[LGW:1] : '0;
    z6_r <= z5_r;
    col6_r <= col5_r; tint6_r <= tint5_r; w6_r <= w5_r; r6_r <= r5_r;
  end

  // ---------------- stage 7: divider setup ----------------
  // quotient of (m << 16) / r is kept to DIV_STEPS bits; anything larger
  // gives zero intensity anyway
  localparam int OW = LGW + ROUGH_W + 6;
  logic ovf_c;
  assign ovf_c = OW'(m6_r) >= (OW'(r6_r) << (DIV_STEPS - LG_FRAC));

  logic                v_dv_r   [DIV_STEPS+1];
  logic                z_dv_r   [DIV_STEPS+1];
  logic [ROUGH_W-1:0]  rem_dv_r [DIV_STEPS+1];
  logic [DIV_STEPS-1:0] q_dv_r  [DIV_STEPS+1];
  logic [LGW-1:0]      m_dv_r   [DIV_STEPS+1];
  logic [ROUGH_W-1:0]  r_dv_r   [DIV_STEPS+1];
  logic [VW-1:0]       col_dv_r [DIV_STEPS+1];
  logic [VW-1:0]       tint_dv_r[DIV_STEPS+1];
  logic [WEIGHT_W-1:0] w_dv_r   [DIV_STEPS+1];

  always_ff @(posedge clk) begin
    rem_dv_r[0]  <= ROUGH_W'(m6_r >> (DIV_STEPS - LG_FRAC));
    q_dv_r[0]    <= '0;
    z_dv_r[0]    <= z6_r | ovf_c;
    m_dv_r[0]    <= m6_r;
    r_dv_r[0]    <= r6_r;
    col_dv_r[0]  <= col6_r;
    tint_dv_r[0] <= tint6_r;
    w_dv_r[0]    <= w6_r;
  end

  // ---------------- divider: one quotient bit per stage ----------------
  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    localparam int B = DIV_STEPS - 1 - k;
    logic           nbit;
    logic [ROUGH_W:0] t_c;
    logic           ge_c;
    if (B >= LG_FRAC) begin : g_mbit
      assign nbit = m_dv_r[k][B-LG_FRAC];
    end else begin : g_zbit
      assign nbit = 1'b0;
    end
    assign t_c  = {rem_dv_r[k], nbit};
    assign ge_c = t_c >= {1'b0, r_dv_r[k]};

    always_ff @(posedge clk) begin
      rem_dv_r[k+1]  <= ge_c ? ROUGH_W'(t_c - {1'b0, r_dv_r[k]}) : t_c[ROUGH_W-1:0];
      q_dv_r[k+1]    <= {q_dv_r[k][DIV_STEPS-2:0], ge_c};
      z_dv_r[k+1]    <= z_dv_r[k];
      m_dv_r[k+1]    <= m_dv_r[k];
      r_dv_r[k+1]    <= r_dv_r[k];
      col_dv_r[k+1]  <= col_dv_r[k];
      tint_dv_r[k+1] <= tint_dv_r[k];
      w_dv_r[k+1]    <= w_dv_r[k];
    end
  end

  // ---------------- post 1: exp2 ----------------
  localparam int QIW = DIV_STEPS - LG_FRAC;
  logic [QIW-1:0]     qi_c;
  logic [LG_FRAC-1:0] g_c;
  logic [INT_W:0]     base_c;
  assign qi_c   = q_dv_r[DIV_STEPS][DIV_STEPS-1:LG_FRAC];
  assign g_c    = q_dv_r[DIV_STEPS][LG_FRAC-1:0];
  assign base_c = (INT_W+1)'(2 ** (LG_FRAC + 1)) - (INT_W+1)'(g_c);

  logic              vp1_r;
  logic [INT_W-1:0]  i_p1_r;
  logic [VW-1:0]     col_p1_r, tint_p1_r;
  logic [WEIGHT_W-1:0] w_p1_r;

  always_ff @(posedge clk) begin
    if (z_dv_r[DIV_STEPS] || qi_c >= QIW'(Q_LIMIT)) begin
      i_p1_r <= '0;
    end else begin
      i_p1_r <= INT_W'(base_c >> ((INT_W+1)'(qi_c) + 1'b1));
    end
    col_p1_r  <= col_dv_r[DIV_STEPS];
    tint_p1_r <= tint_dv_r[DIV_STEPS];
    w_p1_r    <= w_dv_r[DIV_STEPS];
  end

  // ---------------- post 2: weight ----------------
  logic              vp2_r;
  logic [SW-1:0]     s_p2_r;
  logic [VW-1:0]     col_p2_r, tint_p2_r;

  always_ff @(posedge clk) begin
    s_p2_r    <= SW'(i_p1_r) * SW'(w_p1_r);
    col_p2_r  <= col_p1_r;
    tint_p2_r <= tint_p1_r;
  end

  // ---------------- post 3: tint ----------------
  logic              vp3_r;
  logic [TW-1:0]     term_p3_r [3];
  logic [VW-1:0]     col_p3_r;
  logic [SW+CW-1:0]  prod_c [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod_c[i] = (SW+CW)'(s_p2_r) * (SW+CW)'(tint_p2_r[i*CW +: CW]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      term_p3_r[i] <= prod_c[i][31 +: TW];
    end
    col_p3_r <= col_p2_r;
  end

  // ---------------- post 4: saturating add ----------------
  logic [CW+2:0] sum_c [3];
  logic          vp4_r;
  logic [VW-1:0] out_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum_c[i] = (CW+3)'(col_p3_r[i*CW +: CW]) + (CW+3)'(term_p3_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      out_r[i*CW +: CW] <= (sum_c[i] > (CW+3)'({CW{1'b1}})) ? {CW{1'b1}}
                                                             : sum_c[i][CW-1:0];
    end
  end

  // ---------------- valid chain ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0;
      v5_r <= 1'b0; v6_r <= 1'b0;
      for (int k = 0; k <= DIV_STEPS; k++) v_dv_r[k] <= 1'b0;
      vp1_r <= 1'b0; vp2_r <= 1'b0; vp3_r <= 1'b0; vp4_r <= 1'b0;
    end else begin
      v1_r <= in_acc; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r;
      v5_r <= v4_r; v6_r <= v5_r;
      v_dv_r[0] <= v6_r;
      for (int k = 0; k < DIV_STEPS; k++) v_dv_r[k+1] <= v_dv_r[k];
      vp1_r <= v_dv_r[DIV_STEPS]; vp2_r <= vp1_r; vp3_r <= vp2_r;
      vp4_r <= vp3_r;
    end
  end

  assign out_valid     = vp4_r;
  assign out_color_out = out_r;

endmodule

>>> design/bpss_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpss_checker
// Port-level checks for the specular shading pipeline.
// ----------------------------------------------------------------------------
module bpss_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);
  import bpss_pkg::*;

  // every word taken comes out after the fixed latency
  a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##LATENCY out_valid)
    else $error("word taken but no result after pipeline latency");

  // no result without a matching word taken before it
  a_out_from_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result strobe without matching input word");

  // reset flushes the pipeline
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised on a fully pipelined block");

endmodule

bind blinn_phong_specular_shade bpss_checker u_bpss_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the specular shading pipeline: directed corner words and
// random words are predicted in the bench and checked in order at out_valid.
// ----------------------------------------------------------------------------
module tb_top;
  import bpss_pkg::*;

  localparam int CB = 16;
  localparam int VW = 3 * CB;
  localparam logic [CB-1:0] CMAX = {CB{1'b1}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [VW-1:0] eye = '0, light = '0, nrm = '0, col = '0, lcol = '0, scol = '0;
  logic [ROUGH_W-1:0] rough = '0;
  logic [WEIGHT_W-1:0] wgt = '0;
  logic metal = 1'b0;
  logic out_valid;
  logic [VW-1:0] out_color;

  logic [VW-1:0] shaded_q[$];
  int errors = 0;
  int idle_cycles = 0;

  always #2 clk = ~clk;

  blinn_phong_specular_shade #(.COMPONENT_BITS(CB)) dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_eye_dir(eye), .in_light_dir(light), .in_normal_vec(nrm),
    .in_color_in(col), .in_light_color(lcol), .in_surface_color(scol),
    .in_roughness(rough), .in_specular_weight(wgt), .in_metallic(metal),
    .out_valid(out_valid), .out_color_out(out_color)
  );

  function automatic longint comp_s(logic [VW-1:0] v, int i);
    logic signed [CB-1:0] c;
    c = v[i*CB +: CB];
    return longint'(c);
  endfunction

  // Mitchell log2, Q.16
  function automatic longint unsigned mitchell_lg(longint unsigned x);
    int p;
    longint unsigned f;
    p = 63;
    while (p > 0 && x[p] == 1'b0) p--;
    f = ((x << (63 - p)) >> 47) & 64'hFFFF;
    return (longint'(p) << 16) + f;
  endfunction

  function automatic logic [VW-1:0] shade(logic [VW-1:0] e, logic [VW-1:0] l,
      logic [VW-1:0] n, logic [VW-1:0] c, logic [VW-1:0] lc, logic [VW-1:0] sc,
      logic [15:0] r, logic [15:0] w, logic m);
    longint h, nv, d;
    longint unsigned hh, nn, num, den, mm, ex, q, g, rr, inten, s, term, sum;
    logic [VW-1:0] tint, res;
    d = 0; hh = 0; nn = 0; inten = 0;
    for (int i = 0; i < 3; i++) begin
      h = comp_s(e, i) + comp_s(l, i);
      nv = comp_s(n, i);
      d += h * nv;
      hh += h * h;
      nn += nv * nv;
    end
    if (hh != 0 && nn != 0 && d > 0) begin
      num = mitchell_lg(hh) + mitchell_lg(nn);
      den = 2 * mitchell_lg(d);
      mm = (num > den) ? (num - den) / 2 : 0;
      rr = (r != 0) ? r : 1;
      ex = (mm << 16) / rr;
      q = ex >> 16;
      g = ex & 64'hFFFF;
      if (q < Q_LIMIT) inten = (64'd131072 - g) >> (q + 1);
    end
    s = inten * w;
    tint = m ? sc : lc;
    for (int i = 0; i < 3; i++) begin
      term = (s * tint[i*CB +: CB]) >> 31;
      sum = c[i*CB +: CB] + term;
      res[i*CB +: CB] = (sum > CMAX) ? CMAX : sum[CB-1:0];
    end
    return res;
  endfunction

  // send one word after a random gap; prediction pushed on acceptance
  task automatic send_word(logic [VW-1:0] e, logic [VW-1:0] l, logic [VW-1:0] n,
      logic [VW-1:0] c, logic [VW-1:0] lc, logic [VW-1:0] sc,
      logic [15:0] r, logic [15:0] w, logic m, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    eye <= e; light <= l; nrm <= n; col <= c; lcol <= lc; scol <= sc;
    rough <= r; wgt <= w; metal <= m;
    @(posedge clk);
    while (busy) @(posedge clk);
    shaded_q.push_back(shade(e, l, n, c, lc, sc, r, w, m));
    @(negedge clk);
  endtask

  function automatic logic [VW-1:0] rnd_vec();
    return VW'({$urandom, $urandom});
  endfunction

  // small random vector components so that dot products stay well scaled
  function automatic logic [VW-1:0] rnd_dir();
    logic [VW-1:0] v;
    for (int i = 0; i < 3; i++)
      v[i*CB +: CB] = 16'($signed($urandom_range(0, 16384)) - 8192);
    return v;
  endfunction

  function automatic logic [VW-1:0] splat(logic [CB-1:0] x);
    return {x, x, x};
  endfunction

  task automatic test_corners();
    logic [VW-1:0] z, up, one;
    z = '0;
    up = {16'd0, 16'h1000, 16'd0};
    one = splat(16'h1000);
    // aligned, exponent max/min, both tints
    send_word(up, up, up, one, one, splat(16'h2000), 16'd0, 16'hFFFF, 1'b0, 0);
    send_word(up, up, up, one, one, splat(16'h2000), 16'hFFFF, 16'hFFFF, 1'b1, 0);
    send_word(up, up, up, z, one, one, 16'h8000, 16'h8000, 1'b0, 0);
    // zero-length halfway, zero normal, facing away
    send_word(up, ~up + {16'd0, 16'd1, 16'd0} - {16'd0,16'd0,16'd0}, up, one, one, one,
              16'h4000, 16'hFFFF, 1'b0, 0);
    send_word(up, {16'd0, 16'hF000, 16'd0}, up, one, one, one, 16'h4000, 16'hFFFF,
              1'b0, 0);
    send_word(up, up, z, one, one, one, 16'h4000, 16'hFFFF, 1'b0, 0);
    send_word(up, up, {16'd0, 16'hF000, 16'd0}, one, one, one, 16'h4000, 16'hFFFF,
              1'b1, 0);
    // saturation and field extremes
    send_word(up, up, up, splat(CMAX), splat(CMAX), splat(CMAX), 16'hFFFF, 16'hFFFF,
              1'b1, 0);
    send_word(splat(16'h8000), splat(16'h8000), splat(16'h8000), splat(CMAX),
              splat(CMAX), z, 16'd1, 16'hFFFF, 1'b0, 0);
    send_word(splat(16'h7FFF), splat(16'h7FFF), splat(16'h7FFF), z, splat(CMAX),
              splat(CMAX), 16'hFFFF, 16'hFFFF, 1'b0, 0);
    send_word(splat(16'h7FFF), splat(16'h7FFF), splat(16'h8000), z, splat(CMAX),
              splat(CMAX), 16'hFFFF, 16'hFFFF, 1'b1, 0);
    send_word(up, {16'd0, 16'd0, 16'h1000}, up, one, one, one, 16'h0100, 16'h4000,
              1'b0, 0);
    send_word(up, {16'd0, 16'd0, 16'h1000}, up, one, one, one, 16'hFFFF, 16'h4000,
              1'b1, 0);
  endtask

  task automatic test_random();
    logic [VW-1:0] e, l, n;
    logic [15:0] r;
    for (int k = 0; k < 1100; k++) begin
      if ($urandom_range(0, 4) == 0) begin
        e = rnd_vec(); l = rnd_vec(); n = rnd_vec();
      end else begin
        e = rnd_dir(); l = rnd_dir(); n = rnd_dir();
      end
      r = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16384));
      // long runs without gaps keep the pipeline full
      send_word(e, l, n, rnd_vec(), rnd_vec(), rnd_vec(), r, 16'($urandom),
                1'($urandom), (k / 100) % 3 != 1);
    end
    start <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (shaded_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h", out_color);
      end else begin
        logic [VW-1:0] exp_c;
        exp_c = shaded_q.pop_front();
        if (exp_c !== out_color) begin
          errors++;
          if (errors <= 10) $display("color_out: expected %h got %h", exp_c, out_color);
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 2000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_corners();
    test_random();
    while (shaded_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 8) @(negedge clk);
    if (errors == 0 && shaded_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
